/* hw/rtl/dbn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dbn_pkg;

	// Word widths
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 30;
	localparam int STATE_BITS     = 32;

	// Coefficients span (-2, 2): two integer bits above the fraction
	localparam int COEF_BITS  = COEF_FRAC_BITS + 2;
	localparam int PROD_BITS  = COEF_BITS + STATE_BITS;
	// headroom for a sum of three terms
	localparam int ACC_BITS   = PROD_BITS + 2;
	localparam int RND_BITS   = ACC_BITS - COEF_FRAC_BITS;

	localparam int TAPS           = 5;
	localparam int SECTIONS       = 2;
	localparam int TABLES         = 4;
	localparam int ROM_IDX_BITS   = $clog2(SECTIONS * TAPS);
	localparam int TABLE_IDX_BITS = $clog2(TABLES);

	typedef logic signed [COEF_BITS-1:0]  coef_t;
	typedef logic signed [STATE_BITS-1:0] state_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_NOTCH_SIXTY = 1'b0,
		CFG_RATE_SELECT = 1'b1
	} cfg_reg_t;

	// Coefficient order inside one section
	typedef enum logic [2:0] {
		TAP_B0,
		TAP_B1,
		TAP_B2,
		TAP_A1,
		TAP_A2
	} tap_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SUB_A2,
		ST_SUB_END,
		ST_W,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_B_END,
		ST_Y,
		ST_OUT
	} ctrl_state_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,    // latch sample, clear clip flag
		OP_LOAD,     // acc <= x << frac ; prod <= a1*w1
		OP_SUB_A2,   // acc -= prod ; prod <= a2*w2
		OP_SUB_END,  // acc -= prod
		OP_W,        // w <= sat(round(acc))
		OP_B0,       // prod <= b0*w
		OP_B1,       // acc <= prod ; prod <= b1*w1
		OP_B2,       // acc += prod ; prod <= b2*w2
		OP_B_END,    // acc += prod
		OP_Y,        // x <= sat(round(acc)), shift delay pair
		OP_OUT       // result register <= sat to sample width
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sect;
	} dp_cmd_t;

	localparam logic [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

	localparam longint DEN = 64'sd100000000;
	localparam longint ONE = longint'(1) << COEF_FRAC_BITS;

	// 8-decimal constant to fixed point, rounded half away from zero
	function automatic coef_t coef_of(input longint num);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag * ONE + DEN / 2) / DEN;
		return coef_t'((num < 0) ? -q : q);
	endfunction

	// Row = {rate_select, notch_sixty_hz}; per section b0, b1, b2, a1, a2
	localparam coef_t COEF_ROM [TABLES][SECTIONS*TAPS] = '{
		'{coef_of(96508099), coef_of(-156202714), coef_of(96508099),
		  coef_of(-156858163), coef_of(96424138),
		  coef_of(100000000), coef_of(-161854514), coef_of(100000000),
		  coef_of(-161100358), coef_of(96592171)},
		'{coef_of(96508099), coef_of(-140747202), coef_of(96508099),
		  coef_of(-140810535), coef_of(96443153),
		  coef_of(100000000), coef_of(-145839783), coef_of(100000000),
		  coef_of(-145687509), coef_of(96573127)},
		'{coef_of(97948276), coef_of(-60535364), coef_of(97948276),
		  coef_of(-60535364), coef_of(95896552),
		  coef_of(100000000), coef_of(-61881558), coef_of(100000000),
		  coef_of(-66243374), coef_of(93214913)},
		'{coef_of(93137886), coef_of(-11711144), coef_of(93137886),
		  coef_of(-5269865), coef_of(93123336),
		  coef_of(100000000), coef_of(-12573985), coef_of(100000000),
		  coef_of(-18985625), coef_of(93153034)}
	};

endpackage

`default_nettype wire

/* hw/rtl/dbn_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dbn_in_if import dbn_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dbn_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dbn_out_if import dbn_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dbn_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dbn_cfg_if import dbn_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_reg_t index;
	logic     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dbn_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbn_ctrl import dbn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        sect_q;
	logic        out_full_q;
	logic        out_load;

	// result register free, or being drained this cycle
	assign out_load  = !out_full_q || out_ready;
	assign out_valid = out_full_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_LOAD;
			ST_LOAD:    state_d = ST_SUB_A2;
			ST_SUB_A2:  state_d = ST_SUB_END;
			ST_SUB_END: state_d = ST_W;
			ST_W:       state_d = ST_B0;
			ST_B0:      state_d = ST_B1;
			ST_B1:      state_d = ST_B2;
			ST_B2:      state_d = ST_B_END;
			ST_B_END:   state_d = ST_Y;
			ST_Y:       state_d = sect_q ? ST_OUT : ST_LOAD;
			ST_OUT:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.sect = sect_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.op   = in_valid ? OP_START : OP_NONE;
			end
			ST_LOAD:    cmd.op = OP_LOAD;
			ST_SUB_A2:  cmd.op = OP_SUB_A2;
			ST_SUB_END: cmd.op = OP_SUB_END;
			ST_W:       cmd.op = OP_W;
			ST_B0:      cmd.op = OP_B0;
			ST_B1:      cmd.op = OP_B1;
			ST_B2:      cmd.op = OP_B2;
			ST_B_END:   cmd.op = OP_B_END;
			ST_Y:       cmd.op = OP_Y;
			ST_OUT:     cmd.op = out_load ? OP_OUT : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sect_q     <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_Y) begin
				sect_q <= !sect_q;
			end
			if (state_q == ST_OUT && out_load) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	// an accepted sample always starts on the first section
	a_start_first_sect: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_LOAD && !sect_q))
		else $error("sample did not start on first section");

	// the second section's output always goes to the result stage
	a_second_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Y && sect_q) |=> (state_q == ST_OUT))
		else $error("second section did not end in result stage");

	// a result appears only after the result stage loaded it
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_full_q) |-> ($past(state_q) == ST_OUT))
		else $error("result valid without load");

endmodule

`default_nettype wire

/* hw/rtl/dbn_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbn_datapath import dbn_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          cfg_we,
	input  cfg_reg_t                      cfg_index,
	input  logic                          cfg_data,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          clipped
);

	localparam state_t STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
	localparam state_t STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic notch_q;
	logic rate_q;

	state_t sec0_d1_q, sec0_d2_q, sec1_d1_q, sec1_d2_q;
	state_t x_q, w_q;
	logic signed [PROD_BITS-1:0] prod_q;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic                        clip_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clipped_q;

	state_t                      d1, d2, mul_b;
	tap_t                        tap;
	logic [ROM_IDX_BITS-1:0]     rom_idx;
	logic [TABLE_IDX_BITS-1:0]   tbl_idx;
	coef_t                       coef;
	logic signed [PROD_BITS-1:0] product;
	logic signed [ACC_BITS-1:0]  prod_ext, x_ext, acc_rnd;
	logic signed [RND_BITS-1:0]  rnd_val;
	logic                        state_ovf;
	state_t                      state_sat;
	logic                        sample_ovf;
	logic signed [SAMPLE_BITS-1:0] sample_sat;

	assign d1 = cmd.sect ? sec1_d1_q : sec0_d1_q;
	assign d2 = cmd.sect ? sec1_d2_q : sec0_d2_q;

	always_comb begin
		unique case (cmd.op)
			OP_LOAD: begin
				tap   = TAP_A1;
				mul_b = d1;
			end
			OP_SUB_A2: begin
				tap   = TAP_A2;
				mul_b = d2;
			end
			OP_B1: begin
				tap   = TAP_B1;
				mul_b = d1;
			end
			OP_B2: begin
				tap   = TAP_B2;
				mul_b = d2;
			end
			default: begin
				tap   = TAP_B0;
				mul_b = w_q;
			end
		endcase
	end

	assign tbl_idx = {rate_q, notch_q};
	assign rom_idx = cmd.sect ? ROM_IDX_BITS'(TAPS) + ROM_IDX_BITS'(tap)
	                          : ROM_IDX_BITS'(tap);
	assign coef    = COEF_ROM[tbl_idx][rom_idx];
	assign product = PROD_BITS'(coef) * PROD_BITS'(mul_b);

	assign prod_ext = ACC_BITS'(prod_q);
	assign x_ext    = ACC_BITS'(x_q) <<< COEF_FRAC_BITS;

	// round half up, drop fraction, clamp to state width
	assign acc_rnd   = acc_q + $signed(RND_HALF);
	assign rnd_val   = $signed(acc_rnd[ACC_BITS-1:COEF_FRAC_BITS]);
	assign state_ovf = !((&rnd_val[RND_BITS-1:STATE_BITS-1]) ||
	                     !(|rnd_val[RND_BITS-1:STATE_BITS-1]));
	assign state_sat = state_ovf ? (rnd_val[RND_BITS-1] ? STATE_MIN : STATE_MAX)
	                             : rnd_val[STATE_BITS-1:0];

	assign sample_ovf = !((&x_q[STATE_BITS-1:SAMPLE_BITS-1]) ||
	                      !(|x_q[STATE_BITS-1:SAMPLE_BITS-1]));
	assign sample_sat = sample_ovf ? (x_q[STATE_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX)
	                               : x_q[SAMPLE_BITS-1:0];

	// config and delay state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notch_q   <= 1'b0;
			rate_q    <= 1'b0;
			sec0_d1_q <= '0;
			sec0_d2_q <= '0;
			sec1_d1_q <= '0;
			sec1_d2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NOTCH_SIXTY: notch_q <= cfg_data;
				CFG_RATE_SELECT: rate_q  <= cfg_data;
				default:         notch_q <= notch_q;
			endcase
			sec0_d1_q <= '0;
			sec0_d2_q <= '0;
			sec1_d1_q <= '0;
			sec1_d2_q <= '0;
		end else if (cmd.op == OP_Y) begin
			if (cmd.sect) begin
				sec1_d2_q <= sec1_d1_q;
				sec1_d1_q <= w_q;
			end else begin
				sec0_d2_q <= sec0_d1_q;
				sec0_d1_q <= w_q;
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_START: begin
				x_q    <= STATE_BITS'(sample_in);
				clip_q <= 1'b0;
			end
			OP_LOAD: begin
				acc_q  <= x_ext;
				prod_q <= product;
			end
			OP_SUB_A2: begin
				acc_q  <= acc_q - prod_ext;
				prod_q <= product;
			end
			OP_SUB_END: acc_q <= acc_q - prod_ext;
			OP_W: begin
				w_q    <= state_sat;
				clip_q <= clip_q | state_ovf;
			end
			OP_B0: prod_q <= product;
			OP_B1: begin
				acc_q  <= prod_ext;
				prod_q <= product;
			end
			OP_B2: begin
				acc_q  <= acc_q + prod_ext;
				prod_q <= product;
			end
			OP_B_END: acc_q <= acc_q + prod_ext;
			OP_Y: begin
				x_q    <= state_sat;
				clip_q <= clip_q | state_ovf;
			end
			OP_OUT: begin
				sample_out_q <= sample_sat;
				clipped_q    <= clip_q | sample_ovf;
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

`default_nettype wire

/* hw/rtl/dual_biquad_notch_filter_top.sv */
// A new sample word is taken only in the idle state, once the previous one
// has been loaded into the result register. Each section runs on the
//   single shared multiplier (five products, two accumulate drains, two
//   round/saturate steps); two sections, plus the accept and result-load steps.
// The result register lets the next sample start while a result waits.
// Reset (arst_n low, asynchronous): idle, 50 Hz / 500 Hz table, delays zero.
`timescale 1ns / 1ps
`default_nettype none

module dual_biquad_notch_filter_top import dbn_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	dbn_in_if.sink    sample_ch,
	dbn_out_if.source result_ch,
	dbn_cfg_if.sink   cfg
);

	dp_cmd_t cmd;
	logic    cfg_we;

	// Config words are taken at once; a write selects the table and
	// clears both sections' delay pairs.
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	// Sequencer: walks each section through
	// w = x - a1*w1 - a2*w2, then y = b0*w + b1*w1 + b2*w2.
	dbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.cmd       (cmd)
	);

	// Shared multiplier, wide accumulator, coefficient ROM, delay pairs
	// and the result register.
	dbn_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sample_in  (sample_ch.sample_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.sample_out (result_ch.sample_out),
		.clipped    (result_ch.clipped)
	);

endmodule

`default_nettype wire

/* test/dbn_notch_checker.sv */
`timescale 1ns / 1ps

module dbn_notch_checker import dbn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dbn_in_if    sample_ch,
	dbn_out_if   result_ch,
	dbn_cfg_if   cfg,
	output int   mismatches,
	output int   awaiting
);

	localparam int ACC_W = 96;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clipped;
	} filt_word_t;

	// Notch tables in units of 1e-8; row = {rate, sixty}; b0 b1 b2 a1 a2 per section
	localparam longint HUM_TAPS [4][10] = '{
		'{96508099, -156202714, 96508099, -156858163, 96424138,
		  100000000, -161854514, 100000000, -161100358, 96592171},
		'{96508099, -140747202, 96508099, -140810535, 96443153,
		  100000000, -145839783, 100000000, -145687509, 96573127},
		'{97948276, -60535364, 97948276, -60535364, 95896552,
		  100000000, -61881558, 100000000, -66243374, 93214913},
		'{93137886, -11711144, 93137886, -5269865, 93123336,
		  100000000, -12573985, 100000000, -18985625, 93153034}
	};

	longint     tap_q [4][10];
	longint     w_hist [2][2];
	logic       notch_sel;
	logic       rate_sel;
	bit         sat_hit;
	int         mism;
	filt_word_t filtered_q [$];

	function automatic longint to_q(input longint dec);
		longint mag;
		longint q;
		mag = (dec < 0) ? -dec : dec;
		q = (mag * (longint'(1) << COEF_FRAC_BITS) + 64'sd50000000) / 64'sd100000000;
		return (dec < 0) ? -q : q;
	endfunction

	initial begin
		for (int t = 0; t < 4; t++)
			for (int k = 0; k < 10; k++)
				tap_q[t][k] = to_q(HUM_TAPS[t][k]);
	end

	function automatic acc_t rescale(input acc_t a);
		return (a + (acc_t'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
	endfunction

	function automatic longint clamp(input acc_t v, input int bits);
		acc_t hi;
		acc_t lo;
		hi = (acc_t'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			sat_hit = 1'b1;
			return longint'(hi);
		end
		if (v < lo) begin
			sat_hit = 1'b1;
			return longint'(lo);
		end
		return longint'(v);
	endfunction

	function automatic longint run_biquad(input int sect, input int tbl, input longint x);
		acc_t   acc;
		longint w;
		longint y;
		int     base;
		base = sect * 5;
		acc = (acc_t'(x) <<< COEF_FRAC_BITS)
			- acc_t'(tap_q[tbl][base+3]) * acc_t'(w_hist[sect][0])
			- acc_t'(tap_q[tbl][base+4]) * acc_t'(w_hist[sect][1]);
		w = clamp(rescale(acc), STATE_BITS);
		acc = acc_t'(tap_q[tbl][base]) * acc_t'(w)
			+ acc_t'(tap_q[tbl][base+1]) * acc_t'(w_hist[sect][0])
			+ acc_t'(tap_q[tbl][base+2]) * acc_t'(w_hist[sect][1]);
		y = clamp(rescale(acc), STATE_BITS);
		w_hist[sect][1] = w_hist[sect][0];
		w_hist[sect][0] = w;
		return y;
	endfunction

	function automatic filt_word_t filter_sample(input logic signed [SAMPLE_BITS-1:0] s);
		filt_word_t r;
		longint     y;
		int         tbl;
		tbl = int'({rate_sel, notch_sel});
		sat_hit = 1'b0;
		y = run_biquad(0, tbl, longint'(s));
		y = run_biquad(1, tbl, y);
		y = clamp(acc_t'(y), SAMPLE_BITS);
		r.sample = y[SAMPLE_BITS-1:0];
		r.clipped = sat_hit;
		return r;
	endfunction

	function automatic void clear_history();
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				w_hist[i][j] = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filt_word_t want;
		if (!arst_n) begin
			notch_sel = 1'b0;
			rate_sel = 1'b0;
			clear_history();
			filtered_q.delete();
			mism = 0;
			mismatches <= 0;
			awaiting <= 0;
		end else begin
			// any register write flushes both delay pairs
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_NOTCH_SIXTY: notch_sel = cfg.data;
					CFG_RATE_SELECT: rate_sel = cfg.data;
				endcase
				clear_history();
			end
			if (sample_ch.valid && sample_ch.ready)
				filtered_q.push_back(filter_sample(sample_ch.sample_in));
			if (result_ch.valid && result_ch.ready) begin
				if (filtered_q.size() == 0) begin
					if (mism < 10)
						$display("%t unexpected result word %0d/%0b", $realtime,
							result_ch.sample_out, result_ch.clipped);
					mism++;
				end else begin
					want = filtered_q.pop_front();
					if (result_ch.sample_out !== want.sample ||
						result_ch.clipped !== want.clipped) begin
						if (mism < 10)
							$display("%t result mismatch: expected %0d/%0b got %0d/%0b",
								$realtime, want.sample, want.clipped,
								result_ch.sample_out, result_ch.clipped);
						mism++;
					end
				end
			end
			mismatches <= mism;
			awaiting <= filtered_q.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
	import dbn_pkg::*;

	// Random stimulus shapes: each segment of the sample stream picks one
	typedef enum int {
		W_NOISE,   // full-range random words
		W_SQUARE,  // rail-to-rail square wave, random half period
		W_QUIET,   // small values around zero
		W_HOLD,    // held extreme, step response
		W_SCALED   // square wave with random amplitude
	} wave_t;

	// Receiver back-pressure patterns
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} stall_t;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;

	// Extremes, steps, Nyquist toggling, checkerboard bit patterns
	localparam logic signed [SAMPLE_BITS-1:0] CORNER_SAMPLES [23] = '{
		24'sh000000, S_MAX, S_MIN, 24'shFFFFFF, 24'sh000001,
		S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN,
		S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN,
		24'sh555555, 24'shAAAAAA,
		S_MAX, S_MAX, S_MIN, S_MIN
	};

	// {rate_select, notch_sixty_hz} per phase; the first and the repeated
	// settings rewrite current values, which must still flush the delays
	localparam logic [1:0] PHASE_CFG [6] = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b11, 2'b00};
	localparam int PHASE_WORDS = 75;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   burst_left;
	bit   hold_go;

	dbn_in_if  sample_ch ();
	dbn_out_if result_ch ();
	dbn_cfg_if cfg ();

	dual_biquad_notch_filter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg       (cfg)
	);

	dbn_notch_checker i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_ch  (sample_ch),
		.result_ch  (result_ch),
		.cfg        (cfg),
		.mismatches (errors),
		.awaiting   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Offer one sample word and hold it until taken. valid stays high into
	// the next word unless a burst ends with a gap.
	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s);
		int gap;
		sample_ch.valid <= 1'b1;
		sample_ch.sample_in <= s;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_random(input int n);
		wave_t                         wave;
		int                            seg_left;
		int                            pos;
		int                            half;
		logic signed [SAMPLE_BITS-1:0] amp;
		logic signed [SAMPLE_BITS-1:0] s;
		seg_left = 0;
		pos = 0;
		half = 1;
		amp = S_MAX;
		wave = W_NOISE;
		for (int k = 0; k < n; k++) begin
			if (seg_left == 0) begin
				wave = wave_t'($urandom_range(0, 4));
				seg_left = $urandom_range(4, 30);
				half = $urandom_range(1, 12);
				pos = 0;
				amp = SAMPLE_BITS'($urandom_range(1, 8388607));
				if (wave == W_HOLD)
					amp = $urandom_range(0, 1) ? S_MAX : S_MIN;
			end
			case (wave)
				W_NOISE:  s = SAMPLE_BITS'($urandom);
				W_SQUARE: s = ((pos / half) % 2) ? S_MIN : S_MAX;
				W_QUIET:  s = SAMPLE_BITS'(int'($urandom_range(0, 2000)) - 1000);
				W_HOLD:   s = amp;
				W_SCALED: s = ((pos / half) % 2) ? -amp : amp;
			endcase
			send_word(s);
			seg_left--;
			pos++;
		end
		sample_ch.valid <= 1'b0;
	endtask

	// First poll lands on the edge after the last accept, so a fresh
	// expectation is already counted
	task automatic wait_drained();
		int n;
		n = 0;
		do begin
			@(posedge clk);
			n++;
		end while (outstanding != 0 && n < 20000);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (cfg.ready !== 1'b1);
	endtask

	// Receiver: picks its stall pattern at random; once asked, it holds
	// off for a long stretch so the filter backs up into its input
	initial begin
		int     cyc;
		bit     hold_done;
		stall_t pat;
		cyc = 0;
		hold_done = 1'b0;
		pat = RX_OPEN;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			cyc++;
			if (cyc % 64 == 0)
				pat = stall_t'($urandom_range(0, 3));
			case (pat)
				RX_OPEN:   result_ch.ready <= 1'b1;
				RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: result_ch.ready <= (cyc % 4 == 0);
				RX_MOSTLY: result_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n <= 1'b0;
		hold_go <= 1'b0;
		burst_left = 1;
		sample_ch.valid <= 1'b0;
		sample_ch.sample_in <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_NOTCH_SIXTY;
		cfg.data <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words on the reset table (50 Hz / 500 Hz)
		foreach (CORNER_SAMPLES[i])
			send_word(CORNER_SAMPLES[i]);
		sample_ch.valid <= 1'b0;
		wait_drained();

		// one phase per table setting; registers only touched while idle
		foreach (PHASE_CFG[p]) begin
			write_reg(CFG_NOTCH_SIXTY, PHASE_CFG[p][0]);
			write_reg(CFG_RATE_SELECT, PHASE_CFG[p][1]);
			cfg.valid <= 1'b0;
			if (p == 2)
				hold_go <= 1'b1;
			send_random(PHASE_WORDS);
			wait_drained();
		end

		// settle past the pipeline latency, then judge
		repeat (40) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
